// ----- src/wlmd_pkg.sv -----
// wlmd_pkg: shared types and constants of the window local maximum detector
// used by wlmd_cell, wlmd_div, window_local_max_detector and wlmd_check; depends on nothing
`default_nettype none

package wlmd_pkg;

  localparam int PIX_W      = 16;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd3;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 11'd1024;
  localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS  = 3'd1;
  localparam logic [PIX_W-1:0] RST_PEAK_THRESHOLD = 16'd0;

  // divider jobs, run in this order for every word that is not dropped
  localparam logic [1:0] DIV_ARR_ROW = 2'd0;
  localparam logic [1:0] DIV_VD_ROW  = 2'd1;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [DIM_W-1:0] peak_outer;
    logic [DIM_W-1:0] peak_inner;
  } out_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              act;
    logic              ctr;
  } cell_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_MOD,
    ST_WRITE,
    ST_LOAD,
    ST_CWAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- src/wlmd_ram.sv -----
// wlmd_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module wlmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/wlmd_cell.sv -----
// wlmd_cell: one window row of the rotating cell chain (ring slot, active, center)
// depends on wlmd_pkg
`default_nettype none

module wlmd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            shift,
  input  wlmd_pkg::cell_t load_val,
  input  wlmd_pkg::cell_t prev,
  output wlmd_pkg::cell_t q
);
  import wlmd_pkg::*;

  cell_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (load) begin
      q_r <= load_val;
    end else if (shift) begin
      q_r <= prev;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- src/wlmd_div.sv -----
// wlmd_div: restoring divider, one quotient bit per cycle
// depends on wlmd_pkg
`default_nettype none

module wlmd_div #(
  parameter int DW = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [wlmd_pkg::DIM_W-1:0] divisor,
  output logic [DW-1:0]              quo,
  output logic [wlmd_pkg::DIM_W-1:0] rem,
  output logic                       done
);
  import wlmd_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIM_W:0]   rem_sh;
  logic [DIM_W:0]   diff;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign diff   = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DIM_W]) begin
        rem_r <= diff[DIM_W-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIM_W-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ----- src/window_local_max_detector.sv -----
// window_local_max_detector: streaming 2D local maximum detector, top level
// depends on wlmd_pkg, wlmd_ram, wlmd_cell, wlmd_div
//
// Pixels come in scan order on the in_ channel (cmd 0), one word per pixel;
// after the last pixel the host sends radius*width+radius drain words (cmd 1).
// A pixel's verdict is given radius*width+radius words after it; each peak
// leaves on the out_ channel as one-based (outer, inner) coordinates.
// Registers must be written on cfg_ only while idle; the block does not enforce it.
// One word at a time is worked on: in_stall is high from acceptance until the
// word is finished, and the next word can be taken in the cycle after. A word
// that is kept passes setup and check, two divider passes (row and column of the
// written and of the judged pixel), the ring slot states (multiply, modulo),
// write and finish. A verdict adds the load, wait and drain states and a scan
// of all 2*MAX_RADIUS+1 cells of the chain for each window column. A drain
// word given during the image is dropped after the check state.
// A found peak sits in an output register; the next word is taken while it
// waits, and the block holds only when a second peak meets a stalled output.
// Synchronous reset clears the counters and the output valid; the line store
// is not cleared and needs no clearing pass.
`default_nettype none

module window_local_max_detector #(
  parameter int MAX_WIDTH  = wlmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wlmd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = wlmd_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wlmd_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wlmd_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [wlmd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wlmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wlmd_pkg::*;

  localparam int RING  = 2 * MAX_RADIUS + 2;
  localparam int NCELL = 2 * MAX_RADIUS + 1;
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NCELL);
  localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  // row mod RING by reciprocal multiplication, exact for every row below 2**ROW_W
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int SL_SH  = ROW_W + $clog2(RING);
  localparam int SL_M   = ((1 << SL_SH) + RING - 1) / RING;
  localparam int PROD_W = ROW_W + $clog2(SL_M + 1);

  // configuration
  logic [DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [RAD_W-1:0] cfg_rad_r;
  logic [PIX_W-1:0] cfg_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_IMAGE_WIDTH;
      cfg_h_r   <= RST_IMAGE_HEIGHT;
      cfg_rad_r <= RST_WINDOW_RADIUS;
      cfg_thr_r <= RST_PEAK_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IMAGE_WIDTH:    cfg_w_r   <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_h_r   <= cfg_wdata[DIM_W-1:0];
        CFG_WINDOW_RADIUS:  cfg_rad_r <= cfg_wdata[RAD_W-1:0];
        CFG_PEAK_THRESHOLD: cfg_thr_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped values, then frame size and verdict delay
  logic [DIM_W-1:0] w_cl, h_cl;
  logic [RAD_W-1:0] r_cl;
  logic [DIM_W-1:0] w_c_r, h_c_r;
  logic [RAD_W-1:0] r_c_r;
  logic [IDX_W-1:0] total_r, delay_r;

  always_comb begin
    w_cl = cfg_w_r;
    if (cfg_w_r == '0) w_cl = DIM_W'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_cl = DIM_W'(MAX_WIDTH);
    h_cl = cfg_h_r;
    if (cfg_h_r == '0) h_cl = DIM_W'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_cl = DIM_W'(MAX_HEIGHT);
    r_cl = cfg_rad_r;
    if (32'(cfg_rad_r) > MAX_RADIUS) r_cl = RAD_W'(MAX_RADIUS);
  end

  always_ff @(posedge clk) begin
    w_c_r   <= w_cl;
    h_c_r   <= h_cl;
    r_c_r   <= r_cl;
    total_r <= IDX_W'(32'(w_c_r) * 32'(h_c_r));
    delay_r <= IDX_W'(32'(r_c_r) * 32'(w_c_r) + 32'(r_c_r));
  end

  // control state
  state_t           state_r, state_nxt;
  logic             cmd_r;
  logic [PIX_W-1:0] pix_r;
  logic [IDX_W-1:0] arr_r, v_r;
  logic             do_wr_r, do_vd_r;
  logic [1:0]       op_r;
  logic             dstart_r;
  logic [IDX_W-1:0] wrow_r, vrow_r;
  logic [DIM_W-1:0] wcol_r, vcol_r;
  logic [SLOT_W-1:0] wslot_r, vslot_r;
  logic [PROD_W-1:0] wprod_r, vprod_r;
  logic [DIM_W-1:0] y_r, c1_r;
  logic [KW-1:0]    k_r;
  logic [PIX_W-1:0] center_r;
  logic             peak_r, pend_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic [IDX_W-1:0] end_sum, arr_eff, arr_inc;
  assign end_sum = total_r + delay_r;
  assign arr_eff = (arr_r >= end_sum) ? '0 : arr_r;
  assign arr_inc = arr_r + IDX_W'(1);

  // divider
  logic [IDX_W-1:0] div_a;
  logic [IDX_W-1:0] div_q;
  logic [DIM_W-1:0] div_rm;
  logic             div_done;

  always_comb begin
    case (op_r)
      DIV_ARR_ROW: div_a = arr_r;
      default:     div_a = v_r;
    endcase
  end

  wlmd_div #(.DW(IDX_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart_r),
    .dividend (div_a),
    .divisor  (w_c_r),
    .quo      (div_q),
    .rem      (div_rm),
    .done     (div_done)
  );

  // cell chain, cell 0 is the head that addresses the line store
  cell_t load_val [NCELL];
  cell_t cell_q   [NCELL];
  logic  cell_load, cell_shift;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [31:0] sk, rk;
    always_comb begin
      sk = 32'(vslot_r) + 32'(k) + 32'(RING - MAX_RADIUS);
      if (sk >= 32'(RING)) sk = sk - 32'(RING);
      if (sk >= 32'(RING)) sk = sk - 32'(RING);
      rk = 32'(vrow_r) + 32'(k);
      load_val[k].slot = SLOT_W'(sk);
      load_val[k].ctr  = (k == MAX_RADIUS);
      load_val[k].act  = (32'(k) + 32'(r_c_r) >= 32'(MAX_RADIUS))
                      && (32'(k) <= 32'(MAX_RADIUS) + 32'(r_c_r))
                      && (rk >= 32'(MAX_RADIUS))
                      && (rk - 32'(MAX_RADIUS) < 32'(h_c_r));
    end

    wlmd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (cell_load),
      .shift    (cell_shift),
      .load_val (load_val[k]),
      .prev     (cell_q[(k + 1) % NCELL]),
      .q        (cell_q[k])
    );
  end

  // line store
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_waddr = AW'(32'(wslot_r) * 32'(MAX_WIDTH) + 32'(wcol_r));

  wlmd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pix_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window column bounds
  logic [DIM_W-1:0] c0, c1;
  logic [31:0]      csum;
  always_comb begin
    csum = 32'(vcol_r) + 32'(r_c_r);
    c0   = (vcol_r >= DIM_W'(r_c_r)) ? vcol_r - DIM_W'(r_c_r) : '0;
    c1   = (csum < 32'(w_c_r)) ? DIM_W'(csum) : w_c_r - DIM_W'(1);
  end

  logic head_rd, out_free, emit, k_last;
  assign head_rd  = cell_q[0].act && !(cell_q[0].ctr && (y_r == vcol_r));
  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = (k_r == KW'(NCELL - 1));

  always_comb begin
    state_nxt  = state_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = AW'(32'(cell_q[0].slot) * 32'(MAX_WIDTH) + 32'(y_r));
    cell_load  = 1'b0;
    cell_shift = 1'b0;
    emit       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        // drain word during the image is dropped
        if (arr_eff < total_r && cmd_r) state_nxt = ST_IDLE;
        else state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && op_r == DIV_VD_ROW) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_MOD;
      ST_MOD: state_nxt = ST_WRITE;
      ST_WRITE: begin
        ram_we    = do_wr_r;
        state_nxt = do_vd_r ? ST_LOAD : ST_FINISH;
      end
      ST_LOAD: begin
        cell_load = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = AW'(32'(vslot_r) * 32'(MAX_WIDTH) + 32'(vcol_r));
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: state_nxt = ST_SCAN;
      ST_SCAN: begin
        ram_re     = head_rd;
        cell_shift = 1'b1;
        if (k_last && y_r == c1_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!(do_vd_r && peak_r) || out_free) begin
          emit      = do_vd_r && peak_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_r       <= '0;
      op_r        <= DIV_ARR_ROW;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_CHECK: begin
          arr_r <= arr_eff;
          if (!(arr_eff < total_r && cmd_r)) begin
            op_r     <= DIV_ARR_ROW;
            dstart_r <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done && op_r != DIV_VD_ROW) begin
            op_r     <= op_r + 2'd1;
            dstart_r <= 1'b1;
          end
        end
        ST_FINISH: begin
          if (state_nxt == ST_IDLE) arr_r <= (arr_inc >= end_sum) ? '0 : arr_inc;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_data.cmd;
      pix_r <= in_data.pixel_value;
    end
    if (state_r == ST_CHECK) begin
      do_wr_r <= (arr_eff < total_r);
      do_vd_r <= (arr_eff >= delay_r);
      v_r     <= arr_eff - delay_r;
    end
    if (state_r == ST_DIV && div_done) begin
      case (op_r)
        DIV_ARR_ROW: begin wrow_r <= div_q; wcol_r <= div_rm; end
        default:     begin vrow_r <= div_q; vcol_r <= div_rm; end
      endcase
    end
    case (state_r)
      ST_MUL: begin
        wprod_r <= PROD_W'(wrow_r[ROW_W-1:0]) * PROD_W'(SL_M);
        vprod_r <= PROD_W'(vrow_r[ROW_W-1:0]) * PROD_W'(SL_M);
      end
      ST_MOD: begin
        wslot_r <= SLOT_W'(32'(wrow_r[ROW_W-1:0]) - (32'(wprod_r) >> SL_SH) * 32'(RING));
        vslot_r <= SLOT_W'(32'(vrow_r[ROW_W-1:0]) - (32'(vprod_r) >> SL_SH) * 32'(RING));
      end
      ST_LOAD: begin
        y_r  <= c0;
        c1_r <= c1;
        k_r  <= '0;
      end
      ST_CWAIT: begin
        center_r <= ram_rdata;
        peak_r   <= (ram_rdata >= cfg_thr_r);
        pend_r   <= 1'b0;
      end
      ST_SCAN: begin
        pend_r <= head_rd;
        if (pend_r && ram_rdata >= center_r) peak_r <= 1'b0;
        if (k_last) begin
          k_r <= '0;
          y_r <= y_r + DIM_W'(1);
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (pend_r && ram_rdata >= center_r) peak_r <= 1'b0;
      end
      default: ;
    endcase
    if (emit) begin
      out_r.peak_outer <= DIM_W'(32'(vrow_r) + 32'd1);
      out_r.peak_inner <= DIM_W'(32'(vcol_r) + 32'd1);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- src/wlmd_check.sv -----
// wlmd_check: port level checks of window_local_max_detector, bound to the top
// depends on wlmd_pkg
`default_nettype none

module wlmd_check (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire wlmd_pkg::in_word_t              in_data,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire wlmd_pkg::out_word_t             out_data,
  input wire logic                            cfg_we,
  input wire logic [wlmd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input wire logic [wlmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wlmd_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // coordinates are one-based
  a_one_based: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.peak_outer != '0 && out_data.peak_inner != '0)
    else $error("zero peak coordinate");

  // one word at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

endmodule

bind window_local_max_detector wlmd_check u_wlmd_check (.*);

`default_nettype wire
